[rtl/obbot_pkg.sv]
// Package for the 2D box overlap unit: angle constants and sine/cosine table builders.
package obbot_pkg;

	localparam int FRAC_BITS    = 15;
	localparam int FULL_TURN    = 5760;
	localparam int QUARTER_TURN = 1440;
	localparam int EIGHTH_TURN  = 720;
	localparam int ANGLE_W      = 13;
	localparam int TAB_IDX_W    = 10;
	localparam int Q30_W        = 31;
	localparam int DELTA_W      = 17;
	localparam int SIZE_W       = 15;
	localparam int COORD_W      = 16;

	localparam logic [63:0] Q30_ONE      = 64'd1 << 30;
	localparam logic [63:0] RAD_PER_STEP = 64'd1171271;

	typedef logic [Q30_W-1:0] q30_t;
	typedef q30_t q30_tab_t [0:EIGHTH_TURN];

	function automatic q30_t series_sin(input int r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		x  = 64'(r) * RAD_PER_STEP;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - (((x2 * t) >> 30) / 110);
		t  = Q30_ONE - (((x2 * t) >> 30) / 72);
		t  = Q30_ONE - (((x2 * t) >> 30) / 42);
		t  = Q30_ONE - (((x2 * t) >> 30) / 20);
		t  = Q30_ONE - (((x2 * t) >> 30) / 6);
		return Q30_W'((x * t) >> 30);
	endfunction

	function automatic q30_t series_cos(input int r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		x  = 64'(r) * RAD_PER_STEP;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - (((x2 * t) >> 30) / 132);
		t  = Q30_ONE - (((x2 * t) >> 30) / 90);
		t  = Q30_ONE - (((x2 * t) >> 30) / 56);
		t  = Q30_ONE - (((x2 * t) >> 30) / 30);
		t  = Q30_ONE - (((x2 * t) >> 30) / 12);
		t  = Q30_ONE - (((x2 * t) >> 30) / 2);
		return Q30_W'(t);
	endfunction

	function automatic q30_tab_t build_sin_tab();
		q30_tab_t tab;
		for (int i = 0; i <= EIGHTH_TURN; i++) begin
			tab[i] = series_sin(i);
		end
		return tab;
	endfunction

	function automatic q30_tab_t build_cos_tab();
		q30_tab_t tab;
		for (int i = 0; i <= EIGHTH_TURN; i++) begin
			tab[i] = series_cos(i);
		end
		return tab;
	endfunction

endpackage

[rtl/obbot_trig.sv]
// Two-stage sine/cosine unit for two angles: octant fold, table read, quadrant mapping.
module obbot_trig #(
	parameter int TRIG_FRACTION_BITS = obbot_pkg::FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [obbot_pkg::ANGLE_W-1:0]       angle_a,
	input  logic [obbot_pkg::ANGLE_W-1:0]       angle_b,
	output logic signed [TRIG_FRACTION_BITS+1:0] cos_a,
	output logic signed [TRIG_FRACTION_BITS+1:0] sin_a,
	output logic signed [TRIG_FRACTION_BITS+1:0] cos_b,
	output logic signed [TRIG_FRACTION_BITS+1:0] sin_b
);

	localparam int TW  = TRIG_FRACTION_BITS + 2;
	localparam int MW  = TRIG_FRACTION_BITS + 1;
	localparam int SH  = 30 - TRIG_FRACTION_BITS;
	localparam logic [31:0] RND = 32'd1 << (29 - TRIG_FRACTION_BITS);
	localparam int AW  = obbot_pkg::ANGLE_W;
	localparam int IW  = obbot_pkg::TAB_IDX_W;

	localparam obbot_pkg::q30_tab_t SIN_TAB = obbot_pkg::build_sin_tab();
	localparam obbot_pkg::q30_tab_t COS_TAB = obbot_pkg::build_cos_tab();

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	logic [AW-1:0]  ang      [2];
	logic [AW-1:0]  red_a    [2];
	logic [10:0]    rem_c    [2];
	quad_t          quad_c   [2];
	logic           swap_c   [2];
	logic [IW-1:0]  idx_c    [2];

	obbot_pkg::q30_t sin_raw_s1 [2];
	obbot_pkg::q30_t cos_raw_s1 [2];
	quad_t           quad_s1    [2];
	logic            swap_s1    [2];

	logic [31:0]          s_sum   [2];
	logic [31:0]          c_sum   [2];
	logic signed [TW-1:0] s_fold  [2];
	logic signed [TW-1:0] c_fold  [2];
	logic signed [TW-1:0] cos_c   [2];
	logic signed [TW-1:0] sin_c   [2];
	logic signed [TW-1:0] cos_s2  [2];
	logic signed [TW-1:0] sin_s2  [2];

	assign ang[0] = angle_a;
	assign ang[1] = angle_b;

	always_comb begin
		for (int b = 0; b < 2; b++) begin
			red_a[b] = (ang[b] >= AW'(obbot_pkg::FULL_TURN)) ?
				ang[b] - AW'(obbot_pkg::FULL_TURN) : ang[b];
			if (red_a[b] < AW'(obbot_pkg::QUARTER_TURN)) begin
				quad_c[b] = QUAD_0;
				rem_c[b]  = 11'(red_a[b]);
			end else if (red_a[b] < AW'(2 * obbot_pkg::QUARTER_TURN)) begin
				quad_c[b] = QUAD_1;
				rem_c[b]  = 11'(red_a[b] - AW'(obbot_pkg::QUARTER_TURN));
			end else if (red_a[b] < AW'(3 * obbot_pkg::QUARTER_TURN)) begin
				quad_c[b] = QUAD_2;
				rem_c[b]  = 11'(red_a[b] - AW'(2 * obbot_pkg::QUARTER_TURN));
			end else begin
				quad_c[b] = QUAD_3;
				rem_c[b]  = 11'(red_a[b] - AW'(3 * obbot_pkg::QUARTER_TURN));
			end
			swap_c[b] = rem_c[b] > 11'(obbot_pkg::EIGHTH_TURN);
			idx_c[b]  = swap_c[b] ? IW'(11'(obbot_pkg::QUARTER_TURN) - rem_c[b]) :
				rem_c[b][IW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int b = 0; b < 2; b++) begin
				sin_raw_s1[b] <= SIN_TAB[idx_c[b]];
				cos_raw_s1[b] <= COS_TAB[idx_c[b]];
				quad_s1[b]    <= quad_c[b];
				swap_s1[b]    <= swap_c[b];
			end
		end
	end

	always_comb begin
		for (int b = 0; b < 2; b++) begin
			s_sum[b]  = {1'b0, (swap_s1[b] ? cos_raw_s1[b] : sin_raw_s1[b])} + RND;
			c_sum[b]  = {1'b0, (swap_s1[b] ? sin_raw_s1[b] : cos_raw_s1[b])} + RND;
			s_fold[b] = signed'({1'b0, MW'(s_sum[b] >> SH)});
			c_fold[b] = signed'({1'b0, MW'(c_sum[b] >> SH)});
			case (quad_s1[b])
				QUAD_0: begin
					cos_c[b] = c_fold[b];
					sin_c[b] = s_fold[b];
				end
				QUAD_1: begin
					cos_c[b] = -s_fold[b];
					sin_c[b] = c_fold[b];
				end
				QUAD_2: begin
					cos_c[b] = -c_fold[b];
					sin_c[b] = -s_fold[b];
				end
				default: begin
					cos_c[b] = s_fold[b];
					sin_c[b] = -c_fold[b];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int b = 0; b < 2; b++) begin
				cos_s2[b] <= cos_c[b];
				sin_s2[b] <= sin_c[b];
			end
		end
	end

	assign cos_a = cos_s2[0];
	assign sin_a = sin_s2[0];
	assign cos_b = cos_s2[1];
	assign sin_b = sin_s2[1];

endmodule

[rtl/obb_overlap_test_2d_unit.sv]
// Top level of the 2D oriented box overlap unit (separating-axis test).
// Throughput: one transaction per cycle; the whole pipeline holds while the result is stalled.
// Stages: table read, quadrant map, trig products, axis sums, size products, compare.
// Reset clears all stage valid bits; data registers are not reset.
module obb_overlap_test_2d_unit #(
	parameter int TRIG_FRACTION_BITS = obbot_pkg::FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [obbot_pkg::COORD_W-1:0]  first_center_x,
	input  logic signed [obbot_pkg::COORD_W-1:0]  first_center_y,
	input  logic [obbot_pkg::SIZE_W-1:0]          first_width,
	input  logic [obbot_pkg::SIZE_W-1:0]          first_height,
	input  logic [obbot_pkg::ANGLE_W-1:0]         first_angle,
	input  logic signed [obbot_pkg::COORD_W-1:0]  second_center_x,
	input  logic signed [obbot_pkg::COORD_W-1:0]  second_center_y,
	input  logic [obbot_pkg::SIZE_W-1:0]          second_width,
	input  logic [obbot_pkg::SIZE_W-1:0]          second_height,
	input  logic [obbot_pkg::ANGLE_W-1:0]         second_angle,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  overlap
);

	localparam int F   = TRIG_FRACTION_BITS;
	localparam int TW  = F + 2;
	localparam int DW  = obbot_pkg::DELTA_W;
	localparam int ZW  = obbot_pkg::SIZE_W;
	localparam int PPW = 2 * TW;
	localparam int DPW = DW + TW;
	localparam int AW  = 2 * F + 3;
	localparam int DAW = F + 19;
	localparam int MPW = ZW + AW;
	localparam int SW  = 2 * F + 20;

	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	logic signed [DW-1:0] dx_s1, dy_s1, dx_s2, dy_s2;
	logic [ZW-1:0] w0_s1, h0_s1, w1_s1, h1_s1;
	logic [ZW-1:0] w0_s2, h0_s2, w1_s2, h1_s2;
	logic [ZW-1:0] w0_s3, h0_s3, w1_s3, h1_s3;
	logic [ZW-1:0] w0_s4, h0_s4, w1_s4, h1_s4;

	logic signed [TW-1:0] c0, s0, c1, s1;

	logic signed [PPW-1:0] c0c0_s3, s0s0_s3, c1c1_s3, s1s1_s3;
	logic signed [PPW-1:0] c0c1_s3, s0s1_s3, c0s1_s3, s0c1_s3;
	logic signed [DPW-1:0] xc0_s3, ys0_s3, xs0_s3, yc0_s3;
	logic signed [DPW-1:0] xc1_s3, ys1_s3, xs1_s3, yc1_s3;

	logic signed [PPW:0] p00, p11, p01, q01;
	logic signed [DPW:0] d0, d1, d2, d3;
	logic [AW-1:0]  p00_s4, p11_s4, p01_s4, q01_s4;
	logic [DAW-1:0] d0_s4, d1_s4, d2_s4, d3_s4;

	logic [MPW-1:0] w0p00_s5, h0p00_s5, w1p01_s5, h1q01_s5, w1q01_s5, h1p01_s5;
	logic [MPW-1:0] w0p01_s5, h0q01_s5, w1p11_s5, h1p11_s5, w0q01_s5, h0p01_s5;
	logic [SW-1:0]  dist0_s5, dist1_s5, dist2_s5, dist3_s5;

	logic [SW-1:0] sum0, sum1, sum2, sum3;
	logic          overlap_s6;

	function automatic logic [PPW:0] mag_p(input logic signed [PPW:0] v);
		return v[PPW] ? -v : v;
	endfunction

	function automatic logic [DPW:0] mag_d(input logic signed [DPW:0] v);
		return v[DPW] ? -v : v;
	endfunction

	assign en       = !(valid_s6 && out_stall);
	assign in_stall = valid_s6 && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	obbot_trig #(
		.TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
	) u_trig (
		.clk    (clk),
		.en     (en),
		.angle_a(first_angle),
		.angle_b(second_angle),
		.cos_a  (c0),
		.sin_a  (s0),
		.cos_b  (c1),
		.sin_b  (s1)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DW'(second_center_x) - DW'(first_center_x);
			dy_s1 <= DW'(second_center_y) - DW'(first_center_y);
			w0_s1 <= first_width;
			h0_s1 <= first_height;
			w1_s1 <= second_width;
			h1_s1 <= second_height;

			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			w0_s2 <= w0_s1;
			h0_s2 <= h0_s1;
			w1_s2 <= w1_s1;
			h1_s2 <= h1_s1;

			c0c0_s3 <= c0 * c0;
			s0s0_s3 <= s0 * s0;
			c1c1_s3 <= c1 * c1;
			s1s1_s3 <= s1 * s1;
			c0c1_s3 <= c0 * c1;
			s0s1_s3 <= s0 * s1;
			c0s1_s3 <= c0 * s1;
			s0c1_s3 <= s0 * c1;
			xc0_s3  <= dx_s2 * c0;
			ys0_s3  <= dy_s2 * s0;
			xs0_s3  <= dx_s2 * s0;
			yc0_s3  <= dy_s2 * c0;
			xc1_s3  <= dx_s2 * c1;
			ys1_s3  <= dy_s2 * s1;
			xs1_s3  <= dx_s2 * s1;
			yc1_s3  <= dy_s2 * c1;
			w0_s3   <= w0_s2;
			h0_s3   <= h0_s2;
			w1_s3   <= w1_s2;
			h1_s3   <= h1_s2;
		end
	end

	// same-box cross terms cancel exactly, so only these four projections remain
	always_comb begin
		p00 = (PPW+1)'(c0c0_s3) + (PPW+1)'(s0s0_s3);
		p11 = (PPW+1)'(c1c1_s3) + (PPW+1)'(s1s1_s3);
		p01 = (PPW+1)'(c0c1_s3) + (PPW+1)'(s0s1_s3);
		q01 = (PPW+1)'(c0s1_s3) - (PPW+1)'(s0c1_s3);
		d0  = (DPW+1)'(xc0_s3) + (DPW+1)'(ys0_s3);
		d1  = (DPW+1)'(yc0_s3) - (DPW+1)'(xs0_s3);
		d2  = (DPW+1)'(xc1_s3) + (DPW+1)'(ys1_s3);
		d3  = (DPW+1)'(yc1_s3) - (DPW+1)'(xs1_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s4 <= AW'(mag_p(p00));
			p11_s4 <= AW'(mag_p(p11));
			p01_s4 <= AW'(mag_p(p01));
			q01_s4 <= AW'(mag_p(q01));
			d0_s4  <= DAW'(mag_d(d0));
			d1_s4  <= DAW'(mag_d(d1));
			d2_s4  <= DAW'(mag_d(d2));
			d3_s4  <= DAW'(mag_d(d3));
			w0_s4  <= w0_s3;
			h0_s4  <= h0_s3;
			w1_s4  <= w1_s3;
			h1_s4  <= h1_s3;

			w0p00_s5 <= MPW'(w0_s4) * MPW'(p00_s4);
			h0p00_s5 <= MPW'(h0_s4) * MPW'(p00_s4);
			w1p01_s5 <= MPW'(w1_s4) * MPW'(p01_s4);
			h1q01_s5 <= MPW'(h1_s4) * MPW'(q01_s4);
			w1q01_s5 <= MPW'(w1_s4) * MPW'(q01_s4);
			h1p01_s5 <= MPW'(h1_s4) * MPW'(p01_s4);
			w0p01_s5 <= MPW'(w0_s4) * MPW'(p01_s4);
			h0q01_s5 <= MPW'(h0_s4) * MPW'(q01_s4);
			w1p11_s5 <= MPW'(w1_s4) * MPW'(p11_s4);
			h1p11_s5 <= MPW'(h1_s4) * MPW'(p11_s4);
			w0q01_s5 <= MPW'(w0_s4) * MPW'(q01_s4);
			h0p01_s5 <= MPW'(h0_s4) * MPW'(p01_s4);
			dist0_s5 <= SW'(d0_s4) << (F + 1);
			dist1_s5 <= SW'(d1_s4) << (F + 1);
			dist2_s5 <= SW'(d2_s4) << (F + 1);
			dist3_s5 <= SW'(d3_s4) << (F + 1);
		end
	end

	always_comb begin
		sum0 = SW'(w0p00_s5) + SW'(w1p01_s5) + SW'(h1q01_s5);
		sum1 = SW'(h0p00_s5) + SW'(w1q01_s5) + SW'(h1p01_s5);
		sum2 = SW'(w0p01_s5) + SW'(h0q01_s5) + SW'(w1p11_s5);
		sum3 = SW'(w0q01_s5) + SW'(h0p01_s5) + SW'(h1p11_s5);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			overlap_s6 <= !((dist0_s5 > sum0) || (dist1_s5 > sum1) ||
				(dist2_s5 > sum2) || (dist3_s5 > sum3));
		end
	end

	assign out_valid = valid_s6;
	assign overlap   = overlap_s6;

	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> out_valid)
		else $error("input stalled without a blocked result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted transaction did not enter the pipeline");

	assert property (@(posedge clk) disable iff (!arst_n) valid_s4 |-> (p00_s4 != '0))
		else $error("first box axis has zero length");

endmodule

[tb/sv/obb_overlap_test_2d_unit_test.sv]
// Testbench for the 2D oriented box overlap unit: random and directed box pairs checked against a predictor.
`timescale 1ns / 1ps

module obb_overlap_test_2d_unit_test;

	localparam int FB = obbot_pkg::FRAC_BITS;

	typedef struct {
		logic signed [15:0] c1x, c1y, c2x, c2y;
		logic [14:0] w1, h1, w2, h2;
		logic [12:0] a1, a2;
	} box_pair_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [15:0] first_center_x = 0, first_center_y = 0;
	logic signed [15:0] second_center_x = 0, second_center_y = 0;
	logic [14:0] first_width = 0, first_height = 0, second_width = 0, second_height = 0;
	logic [12:0] first_angle = 0, second_angle = 0;
	logic out_valid;
	logic out_stall = 0;
	logic overlap;

	int errors = 0;
	int cycle_count = 0;
	bit stim_done = 0;

	obb_overlap_test_2d_unit dut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic report(input string msg);
		$display("MISMATCH: %s", msg);
		errors++;
	endtask

	function automatic longint unsigned sin_q30(input longint unsigned r);
		longint unsigned x, x2, t;
		x = r * 64'd1171271;
		x2 = (x * x) >> 30;
		t = 64'd1 << 30;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 110;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
		return (x * t) >> 30;
	endfunction

	function automatic longint unsigned cos_q30(input longint unsigned r);
		longint unsigned x, x2, t;
		x = r * 64'd1171271;
		x2 = (x * x) >> 30;
		t = 64'd1 << 30;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 132;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 90;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 56;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 30;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 12;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 2;
		return t;
	endfunction

	function automatic longint round_q(input longint unsigned v);
		return longint'((v + (64'd1 << (29 - FB))) >> (30 - FB));
	endfunction

	function automatic void angle_trig(input logic [12:0] ang, output longint c, output longint s);
		int a, q, r;
		longint c0, s0;
		a = ang;
		if (a >= obbot_pkg::FULL_TURN) a -= obbot_pkg::FULL_TURN;
		q = a / obbot_pkg::QUARTER_TURN;
		r = a % obbot_pkg::QUARTER_TURN;
		if (r <= obbot_pkg::EIGHTH_TURN) begin
			s0 = round_q(sin_q30(r));
			c0 = round_q(cos_q30(r));
		end else begin
			s0 = round_q(cos_q30(obbot_pkg::QUARTER_TURN - r));
			c0 = round_q(sin_q30(obbot_pkg::QUARTER_TURN - r));
		end
		case (q)
			0: begin c = c0; s = s0; end
			1: begin c = -s0; s = c0; end
			2: begin c = -c0; s = -s0; end
			default: begin c = s0; s = -c0; end
		endcase
	endfunction

	function automatic longint unsigned absval(input longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic bit boxes_overlap(input box_pair_t p);
		longint dx, dy, pw, ph;
		longint cs[2], sn[2], wd[2], ht[2], ax[4], ay[4];
		longint unsigned sum, dproj;
		dx = longint'(p.c2x) - longint'(p.c1x);
		dy = longint'(p.c2y) - longint'(p.c1y);
		wd[0] = p.w1; ht[0] = p.h1; wd[1] = p.w2; ht[1] = p.h2;
		angle_trig(p.a1, cs[0], sn[0]);
		angle_trig(p.a2, cs[1], sn[1]);
		for (int j = 0; j < 2; j++) begin
			ax[2*j] = cs[j]; ay[2*j] = sn[j];
			ax[2*j+1] = -sn[j]; ay[2*j+1] = cs[j];
		end
		for (int i = 0; i < 4; i++) begin
			sum = 0;
			for (int j = 0; j < 2; j++) begin
				pw = cs[j] * ax[i] + sn[j] * ay[i];
				ph = cs[j] * ay[i] - sn[j] * ax[i];
				sum += absval(wd[j] * pw);
				sum += absval(ht[j] * ph);
			end
			dproj = absval(dx * ax[i] + dy * ay[i]) << (FB + 1);
			if (dproj > sum) return 0;
		end
		return 1;
	endfunction

	class overlap_scoreboard;
		bit expected_q[$];
		function void note_input(box_pair_t p);
			expected_q.insert(expected_q.size(), boxes_overlap(p));
		endfunction
		task check_result(logic got);
			bit e;
			if (expected_q.size() == 0) begin
				report("result with no transaction pending");
				return;
			end
			e = expected_q.pop_front();
			if (got !== e) report($sformatf("overlap got %b expected %b", got, e));
		endtask
	endclass

	overlap_scoreboard sb = new();

	function automatic box_pair_t rand_pair();
		box_pair_t p;
		int mode;
		mode = $urandom_range(0, 3);
		p.c1x = 16'($urandom); p.c1y = 16'($urandom);
		p.w1 = 15'($urandom); p.h1 = 15'($urandom);
		p.w2 = 15'($urandom); p.h2 = 15'($urandom);
		p.a1 = $urandom_range(0, 3) == 0 ? 13'($urandom) : 13'($urandom_range(0, 5759));
		p.a2 = $urandom_range(0, 3) == 0 ? 13'($urandom) : 13'($urandom_range(0, 5759));
		if (mode == 0) begin
			p.c2x = 16'($urandom); p.c2y = 16'($urandom);
		end else begin
			// nearby centers and sizes so the answer goes both ways
			p.c2x = p.c1x + 16'(signed'($urandom_range(0, 4000)) - 2000);
			p.c2y = p.c1y + 16'(signed'($urandom_range(0, 4000)) - 2000);
			p.w1 = 15'($urandom_range(0, 2000)); p.h1 = 15'($urandom_range(0, 2000));
			p.w2 = 15'($urandom_range(0, 2000)); p.h2 = 15'($urandom_range(0, 2000));
			if (mode == 3) begin
				p.a1 = 13'($urandom_range(0, 4) * 1440);
				p.a2 = 13'($urandom_range(0, 4) * 1440);
			end
		end
		return p;
	endfunction

	function automatic box_pair_t make_pair(int c1x, int c1y, int w1, int h1, int a1,
			int c2x, int c2y, int w2, int h2, int a2);
		box_pair_t p;
		p.c1x = 16'(c1x); p.c1y = 16'(c1y); p.w1 = 15'(w1); p.h1 = 15'(h1); p.a1 = 13'(a1);
		p.c2x = 16'(c2x); p.c2y = 16'(c2y); p.w2 = 15'(w2); p.h2 = 15'(h2); p.a2 = 13'(a2);
		return p;
	endfunction

	task automatic send(input box_pair_t p);
		@(negedge clk);
		in_valid <= 1;
		first_center_x <= p.c1x; first_center_y <= p.c1y;
		first_width <= p.w1; first_height <= p.h1; first_angle <= p.a1;
		second_center_x <= p.c2x; second_center_y <= p.c2y;
		second_width <= p.w2; second_height <= p.h2; second_angle <= p.a2;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		sb.note_input(p);
	endtask

	task automatic idle_gap(input int n);
		if (n == 0) return;
		@(negedge clk);
		in_valid <= 0;
		repeat (n - 1) @(negedge clk);
	endtask

	initial begin
		box_pair_t dir [12];
		int burst;
		repeat (8) @(posedge clk);
		arst_n = 1;
		// touching squares, equal on one axis
		dir[0] = make_pair(0, 0, 10, 10, 0, 10, 0, 10, 10, 0);
		dir[1] = make_pair(0, 0, 10, 10, 0, 11, 0, 10, 10, 0);
		dir[2] = make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		dir[3] = make_pair(-32768, -32768, 32767, 32767, 5759,
			32767, 32767, 32767, 32767, 5759);
		dir[4] = make_pair(32767, 32767, 0, 0, 8191, -32768, -32768, 0, 0, 8191);
		dir[5] = make_pair(0, 0, 100, 0, 720, 40, 40, 0, 100, 2160);
		dir[6] = make_pair(0, 0, 100, 100, 5760, 120, 0, 100, 100, 6480);
		dir[7] = make_pair(0, 0, 100, 100, 720, 120, 0, 100, 100, 0);
		dir[8] = make_pair(5, -5, 32767, 1, 1440, 5, 100, 1, 32767, 2880);
		dir[9] = make_pair(0, 0, 32767, 32767, 4320, -32768, 32767, 32767, 32767, 1);
		dir[10] = make_pair(-1, -1, 1, 1, 719, 1, 1, 1, 1, 721);
		dir[11] = make_pair(0, 0, 20000, 10, 360, 100, 100, 20000, 10, 5400);
		foreach (dir[i]) send(dir[i]);
		for (int n = 0; n < 1000; ) begin
			burst = $urandom_range(1, 30);
			for (int k = 0; k < burst && n < 1000; k++, n++) send(rand_pair());
			idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
		end
		@(negedge clk);
		in_valid <= 0;
		stim_done = 1;
	end

	initial begin
		int phase;
		forever begin
			@(negedge clk);
			phase = (cycle_count / 200) % 4;
			case (phase)
				0: out_stall <= 0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= (cycle_count % 7) < 3;
				default: out_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(overlap);
	end

	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 200000) begin
				$display("obb_overlap_test_2d_unit_test: done, errors");
				$finish;
			end
		end
	end

	initial begin
		wait (stim_done);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && sb.expected_q.size() == 0) begin
			$display("obb_overlap_test_2d_unit_test: done, clean");
		end else begin
			$display("obb_overlap_test_2d_unit_test: done, errors");
		end
		$finish;
	end

endmodule
